// ===== hw/rtl/srrfs_pkg.sv =====
// ----------------------------------------------------------------------------
// srrfs_pkg
// Shared types and constants of the sticky round-robin flow steering core.
// ----------------------------------------------------------------------------
package srrfs_pkg;

    localparam int PORT_W = 16;
    localparam int SOCK_W = 6;
    localparam int CFG_W  = 7;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic done;
        logic out_free;
    } t_status;

endpackage

// ===== hw/rtl/srrfs_ram.sv =====
// ----------------------------------------------------------------------------
// srrfs_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module srrfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/srrfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// srrfs_ctrl
// Controller of the flow steering core: accepts a request, runs the table
// scan and hands the result to the output register.
// ----------------------------------------------------------------------------
module srrfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  srrfs_pkg::t_status i_status,
    output srrfs_pkg::t_cmd    o_cmd
);

    srrfs_pkg::t_state r_state;
    srrfs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srrfs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_stall      = 1'b1;
        case (r_state)
            srrfs_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = srrfs_pkg::ST_SCAN;
                end
            end
            srrfs_pkg::ST_SCAN: begin
                if (i_status.hit || i_status.done) begin
                    if (i_status.out_free) begin
                        o_cmd.finish = 1'b1;
                        n_state      = srrfs_pkg::ST_IDLE;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            default: begin
                n_state = srrfs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/srrfs_dpath.sv =====
// ----------------------------------------------------------------------------
// srrfs_dpath
// Datapath of the flow steering core: flow table, scan counters, round-robin
// counter, socket count register and output register.
// ----------------------------------------------------------------------------
module srrfs_dpath #(
    parameter int TABLE_ENTRIES = 2048,
    parameter int MAX_SOCKETS   = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [srrfs_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic [srrfs_pkg::PORT_W-1:0]  i_src_port,
    input  logic                          i_header_ok,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic                          o_selected,
    output logic [srrfs_pkg::SOCK_W-1:0]  o_socket_index,
    output logic                          o_new_flow,
    output logic                          o_table_full,
    input  srrfs_pkg::t_cmd               i_cmd,
    output srrfs_pkg::t_status            o_status
);

    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ENT_W  = srrfs_pkg::PORT_W + srrfs_pkg::SOCK_W;

    logic [CNT_W-1:0]                r_count;
    logic [CNT_W-1:0]                r_rd_idx;
    logic                            r_cmp_vld;
    logic [srrfs_pkg::SOCK_W-1:0]    r_rr;
    logic [srrfs_pkg::CFG_W-1:0]     r_num;
    logic                            r_out_vld;
    logic [srrfs_pkg::PORT_W-1:0]    r_port;
    logic                            r_ok;
    logic                            r_sel;
    logic [srrfs_pkg::SOCK_W-1:0]    r_sock;
    logic                            r_new;
    logic                            r_full;

    logic                            rd_en;
    logic                            wr_en;
    logic [ENT_W-1:0]                rd_data;
    logic                            hit;
    logic                            tbl_full;
    logic [srrfs_pkg::CFG_W-1:0]     n_eff;
    logic [srrfs_pkg::SOCK_W-1:0]    miss_sock;
    logic [srrfs_pkg::CFG_W-1:0]     sock_inc;
    logic [srrfs_pkg::SOCK_W-1:0]    n_rr;

    assign rd_en    = i_cmd.scan && (r_rd_idx < r_count);
    assign hit      = r_ok && r_cmp_vld
                      && (rd_data[srrfs_pkg::SOCK_W +: srrfs_pkg::PORT_W] == r_port);
    assign tbl_full = (r_count >= CNT_W'(TABLE_ENTRIES));
    assign wr_en    = i_cmd.finish && r_ok && !hit && !tbl_full;

    always_comb begin
        if (r_num == '0) begin
            n_eff = srrfs_pkg::CFG_W'(1);
        end else if (r_num > srrfs_pkg::CFG_W'(MAX_SOCKETS)) begin
            n_eff = srrfs_pkg::CFG_W'(MAX_SOCKETS);
        end else begin
            n_eff = r_num;
        end
        miss_sock = ({1'b0, r_rr} < n_eff) ? r_rr : '0;
        sock_inc  = {1'b0, miss_sock} + srrfs_pkg::CFG_W'(1);
        n_rr      = (sock_inc >= n_eff) ? '0 : sock_inc[srrfs_pkg::SOCK_W-1:0];
    end

    assign o_status.hit      = hit;
    assign o_status.done     = !r_ok || (!r_cmp_vld && (r_rd_idx >= r_count));
    assign o_status.out_free = !r_out_vld || !i_stall;

    srrfs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES),
        .ADDR_W(IDX_W)
    ) u_flow_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_count[IDX_W-1:0]),
        .i_wr_data({r_port, miss_sock}),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_rd_idx[IDX_W-1:0]),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_cmp_vld <= 1'b0;
            r_rr      <= '0;
            r_num     <= srrfs_pkg::CFG_W'(1);
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_vld <= rd_en;
                if (rd_en) begin
                    r_rd_idx <= r_rd_idx + CNT_W'(1);
                end
            end
            if (i_cmd.finish && r_ok && !hit) begin
                r_rr <= n_rr;
                if (!tbl_full) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_port <= i_src_port;
            r_ok   <= i_header_ok;
        end
        if (i_cmd.finish) begin
            r_sel <= r_ok;
            if (!r_ok) begin
                r_sock <= '0;
                r_new  <= 1'b0;
                r_full <= 1'b0;
            end else if (hit) begin
                r_sock <= rd_data[srrfs_pkg::SOCK_W-1:0];
                r_new  <= 1'b0;
                r_full <= 1'b0;
            end else begin
                r_sock <= miss_sock;
                r_new  <= 1'b1;
                r_full <= tbl_full;
            end
        end
    end

    assign o_valid        = r_out_vld;
    assign o_selected     = r_sel;
    assign o_socket_index = r_sock;
    assign o_new_flow     = r_new;
    assign o_table_full   = r_full;

endmodule

// ===== hw/rtl/sticky_round_robin_flow_steering_core.sv =====
// ----------------------------------------------------------------------------
// sticky_round_robin_flow_steering_core
// Steers each UDP datagram to a socket by source port with a sticky flow
// table and a round-robin counter for new flows.
// ----------------------------------------------------------------------------
// A request carries a source port and a header flag on the input channel; it
// is taken when i_valid is high and o_stall is low. One result per request
// leaves on the output channel and is taken when o_valid is high and i_stall
// is low. The socket count register is written through i_cfg_we/i_cfg_wdata;
// the user must write it only while the core is idle; the core does not enforce it.
// After a request is taken, the flow table is scanned one entry per cycle
// from its single read port. Each entry is read into the RAM's registered
// read port and then compared; a hit ends the scan at the matching entry,
// a miss ends it once all flow_count entries are read, and an empty table
// ends it with no read. Requests with a low header flag are not looked up.
// One request is worked on at a time: a new one is taken once the last ends.
// Reset empties the table by clearing the fill count, zeroes the round-robin
// counter and sets the socket count to one; no clearing pass is needed.
// While the receiver stalls, the result is held, a new request may still be
// taken and scanned, and its result waits until the output register frees.
// ----------------------------------------------------------------------------
module sticky_round_robin_flow_steering_core #(
    parameter int TABLE_ENTRIES = 2048,
    parameter int MAX_SOCKETS   = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [srrfs_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [srrfs_pkg::PORT_W-1:0]  i_src_port,
    input  logic                          i_header_ok,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_selected,
    output logic [srrfs_pkg::SOCK_W-1:0]  o_socket_index,
    output logic                          o_new_flow,
    output logic                          o_table_full
);

    srrfs_pkg::t_cmd    cmd;
    srrfs_pkg::t_status status;

    srrfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_status(status),
        .o_cmd   (cmd)
    );

    srrfs_dpath #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MAX_SOCKETS  (MAX_SOCKETS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_src_port    (i_src_port),
        .i_header_ok   (i_header_ok),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_selected    (o_selected),
        .o_socket_index(o_socket_index),
        .o_new_flow    (o_new_flow),
        .o_table_full  (o_table_full),
        .i_cmd         (cmd),
        .o_status      (status)
    );

endmodule
